@@ rtl/stable_min_priority_queue_core_assert.svh @@
// Assertion macros for the priority queue core.
`ifndef STABLE_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SMPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SMPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SMPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SMPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/smpq_pkg.sv @@
package smpq_pkg;

	localparam int OCC_W = 7;

	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_POP   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [30:0] cost;
		logic [30:0] parent_id;
		logic [15:0] operator_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [30:0]      out_parent_id;
		logic [15:0]      out_operator_index;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [30:0] cost;
		logic [30:0] parent_id;
		logic [15:0] operator_index;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PCMP,
		S_PFIN,
		S_POUT
	} state_t;

	typedef struct packed {
		logic       cap;
		logic       rd_push;
		logic       rd_pop;
		logic       shift;
		logic       ins;
		logic       pop;
		logic       clr;
		logic       emit;
		logic [1:0] emit_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       full;
		logic       empty;
		logic       gt;
		logic       ptr_one;
	} dp_stat_t;

endpackage

@@ rtl/smpq_ram.sv @@
module smpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/smpq_ctrl.sv @@
module smpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  smpq_pkg::dp_stat_t stat,
	output smpq_pkg::ctl_cmd_t cmd
);
	import smpq_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				state_nxt = S_IDLE;
				if (stat.func == FUNC_PUSH && !stat.full && !stat.empty) state_nxt = S_PCMP;
				if (stat.func == FUNC_POP && !stat.empty) state_nxt = S_POUT;
			end
			S_PCMP: begin
				if (!stat.gt) state_nxt = S_IDLE;
				else if (stat.ptr_one) state_nxt = S_PFIN;
			end
			S_PFIN: state_nxt = S_IDLE;
			S_POUT: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_status = ST_DONE;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.cap = start;
			end
			S_DECODE: begin
				unique case (stat.func)
					FUNC_PUSH: begin
						if (stat.full) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_FULL;
						end else if (stat.empty) begin
							cmd.ins = 1'b1;
							cmd.emit = 1'b1;
						end else begin
							cmd.rd_push = 1'b1;
						end
					end
					FUNC_POP: begin
						if (stat.empty) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_EMPTY;
						end else begin
							cmd.rd_pop = 1'b1;
						end
					end
					FUNC_CLEAR: begin
						cmd.clr = 1'b1;
						cmd.emit = 1'b1;
					end
					default: cmd.emit = 1'b1;
				endcase
			end
			S_PCMP: begin
				if (stat.gt) begin
					cmd.shift = 1'b1;
					cmd.rd_push = !stat.ptr_one;
				end else begin
					cmd.ins = 1'b1;
					cmd.emit = 1'b1;
				end
			end
			S_PFIN: begin
				cmd.ins = 1'b1;
				cmd.emit = 1'b1;
			end
			S_POUT: begin
				cmd.pop = 1'b1;
				cmd.emit = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/smpq_dp.sv @@
module smpq_dp #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smpq_pkg::req_t     req,
	input  smpq_pkg::ctl_cmd_t cmd,
	output smpq_pkg::dp_stat_t stat,
	output logic               done,
	output smpq_pkg::rsp_t     rsp
);
	import smpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_EXT = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST    = AW'(CAPACITY - 1);

	req_t          req_q;
	logic [CW-1:0] count_q, count_nxt;
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] head_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic [AW-1:0] rd_lidx, raddr, waddr;
	logic          we;
	entry_t        wdata, rdata, new_entry;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
		logic [AW:0] sum;
		sum = {1'b0, h} + {1'b0, l};
		if (sum >= CAP_EXT) sum = sum - CAP_EXT;
		return sum[AW-1:0];
	endfunction

	assign new_entry = '{cost: req_q.cost, parent_id: req_q.parent_id,
		operator_index: req_q.operator_index};

	always_comb begin
		if (cmd.rd_pop) rd_lidx = '0;
		else if (cmd.shift) rd_lidx = AW'(ptr_q - CW'(2));
		else if (cmd.rd_push) rd_lidx = AW'(ptr_q - CW'(1));
		else rd_lidx = '0;
	end

	assign raddr = phys(head_q, rd_lidx);
	assign waddr = phys(head_q, AW'(ptr_q));
	assign we    = cmd.shift | cmd.ins;
	assign wdata = cmd.shift ? rdata : new_entry;

	smpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) count_nxt = count_q + CW'(1);
		else if (cmd.pop) count_nxt = count_q - CW'(1);
		else if (cmd.clr) count_nxt = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= cmd.emit;
			if (cmd.pop) head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req;
			ptr_q <= count_q;
		end else if (cmd.shift) begin
			ptr_q <= ptr_q - CW'(1);
		end
		if (cmd.emit) begin
			rsp_q.status             <= cmd.emit_status;
			rsp_q.out_parent_id      <= cmd.pop ? rdata.parent_id : '0;
			rsp_q.out_operator_index <= cmd.pop ? rdata.operator_index : '0;
			rsp_q.occupancy          <= OCC_W'(count_nxt);
		end
	end

	assign stat.func    = req_q.func;
	assign stat.full    = (count_q == CAP_CNT);
	assign stat.empty   = (count_q == '0);
	assign stat.gt      = (rdata.cost > req_q.cost);
	assign stat.ptr_one = (ptr_q == CW'(1));

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ rtl/stable_min_priority_queue_core.sv @@
// Sorted queue of up to CAPACITY entries held in one RAM as a ring, oldest of the
// lowest cost at the head. A clear, a dropped push, a pop of an empty queue, a push to
// an empty queue and a no-op finish in the decode state; a pop reads the head, then
// emits it from the pop state; a push to a non-empty queue walks back over the k held
// entries of higher cost, one RAM read and shift per cycle, then inserts.
// busy is high from the cycle after start until the cycle before done; done pulses
// one cycle and must be taken then, and a new start may come in that cycle.
module stable_min_priority_queue_core #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  smpq_pkg::req_t req,
	output logic           done,
	output smpq_pkg::rsp_t rsp
);
	import smpq_pkg::*;
	`include "stable_min_priority_queue_core_assert.svh"

	ctl_cmd_t cmd;
	dp_stat_t stat;

	smpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	smpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	`SMPQ_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`SMPQ_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	`SMPQ_ASSERT_IMP(a_empty_zero, clk, arst_n, done && rsp.status == ST_EMPTY, rsp.out_parent_id == '0 && rsp.occupancy == '0)

endmodule
